// ----- sv/wtsp_pkg.sv -----
// Shared constants and types for the world-to-screen projection pipeline.
// Depends on nothing; imported by wtsp_div, world_to_screen_projection and the testbench.
`default_nettype none
package wtsp_pkg;

    // Point and camera formats.
    localparam int POS_W  = 20;   // signed Q16.4 coordinate
    localparam int AXIS_W = 16;   // signed Q1.14 axis component
    localparam int DIFF_W = POS_W + 1;
    localparam int PROD_W = DIFF_W + AXIS_W;   // one term of a dot product, Q.18
    localparam int VIEW_W = PROD_W + 2;        // sum of three terms, Q.18
    localparam int MAG_W  = VIEW_W - 2;        // magnitude of a visible depth
    localparam int HALF_W = 12;
    localparam int PROJ_W = 16;
    localparam int PIX_W  = 16;
    localparam int DEP_W  = 20;

    // Divider operand widths.
    localparam int SNUM_W = HALF_W + 1 + VIEW_W;      // half extent times view coordinate
    localparam int FRAC_SH = 12;                      // Q4.12 projection factor scaling
    localparam int NUM_W  = 62;                       // numerator magnitude, below 2^61
    localparam int DEN_W  = PROJ_W + MAG_W;           // projection factor times depth
    localparam int QBITS  = 18;                       // quotient bits before saturation
    localparam int REM_W  = DEN_W + QBITS;

    // Near limit 0.65 in Q.18, rounded up.
    localparam logic signed [VIEW_W-1:0] NEAR_Q18 = VIEW_W'(170394);
    localparam logic [DEP_W-1:0] DEP_MAX = '1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_RGT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_UP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_FWD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_H   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_Y   = 3'd7;
    localparam int CFG_DATA_W = 3 * POS_W;

    // Result of one division: quotient magnitude and what is needed to floor it.
    typedef struct packed {
        logic [QBITS-1:0] q;
        logic             rem_nz;
        logic             ovf;
        logic             neg;
    } t_div_res;

endpackage
`default_nettype wire

// ----- sv/wtsp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for unsigned magnitudes.
// Depends on wtsp_pkg for operand widths and the result struct.
`default_nettype none
module wtsp_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [wtsp_pkg::NUM_W-1:0] i_num,
    input  wire logic [wtsp_pkg::DEN_W-1:0] i_den,
    input  wire logic                      i_neg,
    output wtsp_pkg::t_div_res             o_res
);
    import wtsp_pkg::*;

    logic [NUM_W-1:0] r_rem [0:QBITS];
    logic [DEN_W-1:0] r_den [0:QBITS];
    logic [QBITS-1:0] r_q   [0:QBITS];
    logic             r_ovf [0:QBITS];
    logic             r_neg [0:QBITS];

    // Entry stage: a quotient of 2^QBITS or more only ever saturates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= {{(REM_W-NUM_W){1'b0}}, i_num} >= {i_den, {QBITS{1'b0}}};
            r_neg[0] <= i_neg;
        end
    end

    for (genvar j = 1; j <= QBITS; j++) begin : g_step
        localparam int K = QBITS - j;
        logic [REM_W-1:0] n_sh;
        logic [REM_W-1:0] n_ext;
        logic [REM_W-1:0] n_diff;
        logic             n_ge;

        assign n_sh   = {{QBITS{1'b0}}, r_den[j-1]} << K;
        assign n_ext  = {{(REM_W-NUM_W){1'b0}}, r_rem[j-1]};
        assign n_ge   = n_ext >= n_sh;
        assign n_diff = n_ext - n_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_ge ? n_diff[NUM_W-1:0] : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (n_ge ? (QBITS'(1) << K) : '0);
                r_den[j] <= r_den[j-1];
                r_ovf[j] <= r_ovf[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end
    end

    assign o_res.q      = r_q[QBITS];
    assign o_res.rem_nz = |r_rem[QBITS];
    assign o_res.ovf    = r_ovf[QBITS];
    assign o_res.neg    = r_neg[QBITS];

endmodule
`default_nettype wire

// ----- sv/world_to_screen_projection.sv -----
// Perspective projection of world points to screen pixels; top level.
// Depends on wtsp_pkg and wtsp_div.
// Throughput: one item per cycle; the whole pipeline advances together and halts only
// while a finished result sits in the output register and the receiver stalls.
// Reset (synchronous, active low) clears all valid bits and loads the default camera.
`default_nettype none
module world_to_screen_projection (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [wtsp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [wtsp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // point input
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]     i_point_x,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]     i_point_y,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]     i_point_z,
    // projected output
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [wtsp_pkg::PIX_W-1:0]          o_screen_x,
    output logic signed [wtsp_pkg::PIX_W-1:0]          o_screen_y,
    output logic [wtsp_pkg::DEP_W-1:0]                 o_depth,
    output logic                                       o_visible
);
    import wtsp_pkg::*;

    // Floors the quotient, adds the half extent and saturates to a pixel.
    function automatic logic signed [PIX_W-1:0] f_pixel(t_div_res r, logic [HALF_W-1:0] half);
        logic        [QBITS+1:0] mag;
        logic signed [QBITS+1:0] q;
        logic signed [QBITS+2:0] s;
        mag = {2'b00, r.q} + (QBITS+2)'(r.rem_nz & r.neg);
        q   = r.neg ? -$signed(mag) : $signed(mag);
        s   = $signed({{(QBITS+3-HALF_W){1'b0}}, half}) + {q[QBITS+1], q};
        if (r.ovf) begin
            return r.neg ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
        end else if (s > (QBITS+3)'(32767)) begin
            return {1'b0, {(PIX_W-1){1'b1}}};
        end else if (s < -(QBITS+3)'(32768)) begin
            return {1'b1, {(PIX_W-1){1'b0}}};
        end
        return s[PIX_W-1:0];
    endfunction

    // ---------------------------------------------------------------- configuration
    logic [3*POS_W-1:0]  r_cam_pos;
    logic [3*AXIS_W-1:0] r_axis [0:2];   // right, up, forward
    logic [HALF_W-1:0]   r_half_w, r_half_h;
    logic [PROJ_W-1:0]   r_proj_x, r_proj_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_pos <= '0;
            r_axis[0] <= 48'd16384;
            r_axis[1] <= 48'd16384 << 16;
            r_axis[2] <= 48'd16384 << 32;
            r_half_w  <= 12'd960;
            r_half_h  <= 12'd540;
            r_proj_x  <= 16'd4096;
            r_proj_y  <= 16'd4096;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CAM_POS: r_cam_pos <= i_cfg_data;
                CFG_CAM_RGT: r_axis[0] <= i_cfg_data[3*AXIS_W-1:0];
                CFG_CAM_UP:  r_axis[1] <= i_cfg_data[3*AXIS_W-1:0];
                CFG_CAM_FWD: r_axis[2] <= i_cfg_data[3*AXIS_W-1:0];
                CFG_HALF_W:  r_half_w  <= i_cfg_data[HALF_W-1:0];
                CFG_HALF_H:  r_half_h  <= i_cfg_data[HALF_W-1:0];
                CFG_PROJ_X:  r_proj_x  <= i_cfg_data[PROJ_W-1:0];
                CFG_PROJ_Y:  r_proj_y  <= i_cfg_data[PROJ_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero projection factor counts as one LSB.
    logic [PROJ_W-1:0] n_px, n_py;
    assign n_px = (r_proj_x == '0) ? PROJ_W'(1) : r_proj_x;
    assign n_py = (r_proj_y == '0) ? PROJ_W'(1) : r_proj_y;

    // ---------------------------------------------------------------- flow control
    // Every stage moves on the same enable; it drops only when the output register
    // holds a result that the receiver is not taking.
    logic n_en;
    assign n_en    = !(o_valid && i_stall);
    assign o_stall = !n_en;

    // Valid bits of the front stages, the divider stages and the output register.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_dv [0:QBITS];
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            for (int k = 0; k <= QBITS; k++) r_dv[k] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (n_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_dv[0] <= r_v5;
            for (int k = 1; k <= QBITS; k++) r_dv[k] <= r_dv[k-1];
            r_out_valid <= r_dv[QBITS];
        end
    end

    // ---------------------------------------------------------------- stage 1: offset
    logic signed [POS_W-1:0]  n_pt [0:2];
    logic signed [DIFF_W-1:0] r_d  [0:2];
    assign n_pt[0] = i_point_x;
    assign n_pt[1] = i_point_y;
    assign n_pt[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= DIFF_W'(n_pt[i]) - DIFF_W'($signed(r_cam_pos[POS_W*i +: POS_W]));
            end
        end
    end

    // ---------------------------------------------------------------- stage 2: products
    // Nine independent products, one per axis component.
    logic signed [PROD_W-1:0] r_p [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 3; i++) begin
                    r_p[a][i] <= PROD_W'(r_d[i] * $signed(r_axis[a][AXIS_W*i +: AXIS_W]));
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 3: sums
    logic signed [VIEW_W-1:0] r_vx, r_vy, r_vz;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_vx <= VIEW_W'(r_p[0][0]) + VIEW_W'(r_p[0][1]) + VIEW_W'(r_p[0][2]);
            r_vy <= VIEW_W'(r_p[1][0]) + VIEW_W'(r_p[1][1]) + VIEW_W'(r_p[1][2]);
            r_vz <= VIEW_W'(r_p[2][0]) + VIEW_W'(r_p[2][1]) + VIEW_W'(r_p[2][2]);
        end
    end

    // ---------------------------------------------------------------- stage 4: scaling
    // Numerators are half extent times view coordinate; denominators are projection
    // factor times depth. The near test and the depth output are settled here too.
    logic signed [SNUM_W-1:0] r_mx, r_my;
    logic [DEN_W-1:0]         r_den_x4, r_den_y4;
    logic                     r_vis4;
    logic [DEP_W-1:0]         r_dep4;
    logic [VIEW_W-15:0]       n_dep_raw;

    assign n_dep_raw = r_vz[VIEW_W-1:14];

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_mx     <= SNUM_W'($signed({1'b0, r_half_w}) * r_vx);
            r_my     <= SNUM_W'($signed({1'b0, r_half_h}) * r_vy);
            r_den_x4 <= DEN_W'(n_px * r_vz[MAG_W-1:0]);
            r_den_y4 <= DEN_W'(n_py * r_vz[MAG_W-1:0]);
            r_vis4   <= r_vz >= NEAR_Q18;
            r_dep4   <= (n_dep_raw > {{(VIEW_W-14-DEP_W){1'b0}}, DEP_MAX}) ?
                        DEP_MAX : n_dep_raw[DEP_W-1:0];
        end
    end

    // ---------------------------------------------------------------- stage 5: magnitudes
    // The vertical axis points down the screen, so its numerator changes sign.
    logic [SNUM_W-1:0] n_absx, n_absy;
    logic [NUM_W-1:0]  r_numx, r_numy;
    logic [DEN_W-1:0]  r_den_x5, r_den_y5;
    logic              r_negx, r_negy, r_vis5;
    logic [DEP_W-1:0]  r_dep5;

    assign n_absx = r_mx[SNUM_W-1] ? SNUM_W'(-r_mx) : SNUM_W'(r_mx);
    assign n_absy = r_my[SNUM_W-1] ? SNUM_W'(-r_my) : SNUM_W'(r_my);

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_numx   <= {n_absx[NUM_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
            r_numy   <= {n_absy[NUM_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
            r_negx   <= r_mx[SNUM_W-1];
            r_negy   <= !r_my[SNUM_W-1] && (r_my != '0);
            r_den_x5 <= r_den_x4;
            r_den_y5 <= r_den_y4;
            r_vis5   <= r_vis4;
            r_dep5   <= r_dep4;
        end
    end

    // ---------------------------------------------------------------- dividers
    t_div_res n_qx, n_qy;

    wtsp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (r_numx),
        .i_den (r_den_x5),
        .i_neg (r_negx),
        .o_res (n_qx)
    );

    wtsp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (r_numy),
        .i_den (r_den_y5),
        .i_neg (r_negy),
        .o_res (n_qy)
    );

    // Near test and depth ride alongside the divider stages.
    logic             r_vis_d [0:QBITS];
    logic [DEP_W-1:0] r_dep_d [0:QBITS];

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_vis_d[0] <= r_vis5;
            r_dep_d[0] <= r_dep5;
            for (int k = 1; k <= QBITS; k++) begin
                r_vis_d[k] <= r_vis_d[k-1];
                r_dep_d[k] <= r_dep_d[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- output stage
    // A point nearer than the limit gives an all-zero result.
    logic signed [PIX_W-1:0] r_out_x, r_out_y;
    logic [DEP_W-1:0]        r_out_dep;
    logic                    r_out_vis;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out_vis <= r_vis_d[QBITS];
            r_out_x   <= r_vis_d[QBITS] ? f_pixel(n_qx, r_half_w) : '0;
            r_out_y   <= r_vis_d[QBITS] ? f_pixel(n_qy, r_half_h) : '0;
            r_out_dep <= r_vis_d[QBITS] ? r_dep_d[QBITS] : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_screen_x = r_out_x;
    assign o_screen_y = r_out_y;
    assign o_depth    = r_out_dep;
    assign o_visible  = r_out_vis;

    // ---------------------------------------------------------------- checks
    // A hidden point carries no coordinates.
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_screen_x == '0 && o_screen_y == '0 && o_depth == '0)
        else $error("hidden point with nonzero fields");

    // A visible point has at least the near limit, rounded down, as depth.
    a_vis_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> o_depth >= DEP_W'(10))
        else $error("visible point below near depth");

    // While the pipeline is halted, the valid bits inside it do not move.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_en |=> $stable(r_dv[QBITS]) && $stable(r_v5) && $stable(r_out_valid))
        else $error("pipeline moved while halted");

endmodule
`default_nettype wire

// ----- tb/wtsp_checker.sv -----
// Projection checker: watches the point and pixel channels, predicts each result
// and compares it field by field. Depends on wtsp_pkg and the configuration port.
`timescale 1ns / 1ps
module wtsp_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [wtsp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [wtsp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_valid,
    input  wire logic                                  i_in_stall,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]     i_point_x,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]     i_point_y,
    input  wire logic signed [wtsp_pkg::POS_W-1:0]     i_point_z,
    input  wire logic                                  i_out_valid,
    input  wire logic                                  i_out_stall,
    input  wire logic signed [wtsp_pkg::PIX_W-1:0]     i_screen_x,
    input  wire logic signed [wtsp_pkg::PIX_W-1:0]     i_screen_y,
    input  wire logic [wtsp_pkg::DEP_W-1:0]            i_depth,
    input  wire logic                                  i_visible,
    output int                                         o_errors,
    output int                                         o_pending
);
    import wtsp_pkg::*;

    typedef struct {
        logic signed [PIX_W-1:0] sx;
        logic signed [PIX_W-1:0] sy;
        logic [DEP_W-1:0]        dep;
        logic                    vis;
    } t_pixel;

    logic [59:0] cam_pos;
    logic [47:0] axis_r, axis_u, axis_f;
    logic [11:0] half_w, half_h;
    logic [15:0] prj_x, prj_y;
    t_pixel      pixels_due[$];

    assign o_pending = pixels_due.size();

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint axis_dot(longint dx, longint dy, longint dz, logic [47:0] a);
        return dx * longint'($signed(a[15:0])) + dy * longint'($signed(a[31:16]))
             + dz * longint'($signed(a[47:32]));
    endfunction

    function automatic t_pixel project(logic signed [19:0] x, logic signed [19:0] y,
                                       logic signed [19:0] z);
        t_pixel r;
        longint dx, dy, dz, vx, vy, vz, px, py, hw, hh, dp;
        dx = longint'(x) - longint'($signed(cam_pos[19:0]));
        dy = longint'(y) - longint'($signed(cam_pos[39:20]));
        dz = longint'(z) - longint'($signed(cam_pos[59:40]));
        vx = axis_dot(dx, dy, dz, axis_r);
        vy = axis_dot(dx, dy, dz, axis_u);
        vz = axis_dot(dx, dy, dz, axis_f);
        r = '{sx: '0, sy: '0, dep: '0, vis: 1'b0};
        if (vz < 170394) return r;
        px = (prj_x == 0) ? 1 : prj_x;
        py = (prj_y == 0) ? 1 : prj_y;
        hw = half_w;
        hh = half_h;
        r.sx = PIX_W'(clamp16(hw + fdiv(hw * vx * 4096, px * vz)));
        r.sy = PIX_W'(clamp16(hh + fdiv(-(hh * vy * 4096), py * vz)));
        dp = vz >>> 14;
        r.dep = (dp > 1048575) ? DEP_MAX : DEP_W'(dp);
        r.vis = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_pixel e;
        if (!i_rst_n) begin
            cam_pos = '0;
            axis_r  = 48'd16384;
            axis_u  = 48'd16384 << 16;
            axis_f  = 48'd16384 << 32;
            half_w  = 12'd960;
            half_h  = 12'd540;
            prj_x   = 16'd4096;
            prj_y   = 16'd4096;
            pixels_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CAM_POS: cam_pos = i_cfg_data[59:0];
                    CFG_CAM_RGT: axis_r  = i_cfg_data[47:0];
                    CFG_CAM_UP:  axis_u  = i_cfg_data[47:0];
                    CFG_CAM_FWD: axis_f  = i_cfg_data[47:0];
                    CFG_HALF_W:  half_w  = i_cfg_data[11:0];
                    CFG_HALF_H:  half_h  = i_cfg_data[11:0];
                    CFG_PROJ_X:  prj_x   = i_cfg_data[15:0];
                    CFG_PROJ_Y:  prj_y   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                pixels_due.push_back(project(i_point_x, i_point_y, i_point_z));
            if (i_out_valid && !i_out_stall) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    e = pixels_due.pop_front();
                    if (i_screen_x !== e.sx) report_mismatch("screen_x", i_screen_x, e.sx);
                    if (i_screen_y !== e.sy) report_mismatch("screen_y", i_screen_y, e.sy);
                    if (i_depth !== e.dep) report_mismatch("depth", i_depth, e.dep);
                    if (i_visible !== e.vis) report_mismatch("visible", i_visible, e.vis);
                end
            end
        end
    end
endmodule

// ----- tb/tb_world_to_screen_projection.sv -----
// Testbench top for the world-to-screen projection block: drives points and camera
// settings, stalls the output at random, and gives the verdict. Depends on wtsp_checker.
`timescale 1ns / 1ps
module tb_world_to_screen_projection;
    import wtsp_pkg::*;

    logic i_clk, i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_valid, o_stall;
    logic signed [POS_W-1:0] i_point_x, i_point_y, i_point_z;
    logic o_valid, i_stall;
    logic signed [PIX_W-1:0] o_screen_x, o_screen_y;
    logic [DEP_W-1:0] o_depth;
    logic o_visible;
    int   errors, pending;

    // Phases of the output stall: random, none at all, and one long hold-off.
    logic quiet_rx, hold_rx;
    logic quiet_tx;

    world_to_screen_projection dut (.*);

    wtsp_checker chk (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall), .i_point_x, .i_point_y, .i_point_z,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_screen_x(o_screen_x),
        .i_screen_y(o_screen_y), .i_depth(o_depth), .i_visible(o_visible),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: stalls at random, about six times in a hundred, unless a phase says otherwise.
    always @(negedge i_clk) begin
        if (hold_rx) i_stall <= 1'b1;
        else if (quiet_rx) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 6);
    end

    // Send one point, possibly after a random gap, and wait until it is taken.
    // Valid stays high on return so that the next point can follow without a gap;
    // drain() lowers it.
    task automatic send_point(logic [19:0] x, logic [19:0] y, logic [19:0] z);
        while (!quiet_tx && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Let the pipeline empty before touching the camera.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic logic [47:0] pack_axis(int ax, int ay, int az);
        return {16'(az), 16'(ay), 16'(ax)};
    endfunction

    function automatic logic [19:0] rand_coord(bit wide);
        if (wide) return 20'($urandom);
        return 20'($signed($urandom_range(4000)) - 2000);
    endfunction

    // Camera looking down +z with random small rotations of the axes, or fully random.
    task automatic random_camera(bit wild);
        int s;
        if (wild) begin
            write_reg(CFG_CAM_POS, 60'({$urandom, $urandom}));
            write_reg(CFG_CAM_RGT, 60'({$urandom, $urandom}));
            write_reg(CFG_CAM_UP,  60'({$urandom, $urandom}));
            write_reg(CFG_CAM_FWD, 60'({$urandom, $urandom}));
        end else begin
            s = $urandom_range(2000);
            write_reg(CFG_CAM_POS, {20'($urandom_range(400)), 20'($urandom_range(400)),
                                    20'($urandom_range(400))});
            write_reg(CFG_CAM_RGT, 60'(pack_axis(16384 - s, 0, s)));
            write_reg(CFG_CAM_UP,  60'(pack_axis(0, 16384 - s, s)));
            write_reg(CFG_CAM_FWD, 60'(pack_axis(-s, -s, 16384 - s)));
        end
        write_reg(CFG_HALF_W, 60'($urandom_range(4095)));
        write_reg(CFG_HALF_H, 60'($urandom_range(4095)));
        write_reg(CFG_PROJ_X, 60'($urandom_range(65535)));
        write_reg(CFG_PROJ_Y, 60'($urandom_range(65535)));
    endtask

    initial begin
        int phase, k;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        quiet_rx = 1'b0;
        hold_rx  = 1'b0;
        quiet_tx = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed points with the default camera: near limit edges (0.65 is 10.4 in
        // Q16.4, so z of 10 is hidden and 11 visible), extremes, and off-screen pixels.
        send_point('0, '0, 20'sd10);
        send_point('0, '0, 20'sd11);
        send_point('0, '0, 20'sd160);
        send_point(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
        send_point(20'sh80000, 20'sh80000, 20'sh7FFFF);
        send_point(20'sh7FFFF, 20'sh80000, 20'sd11);
        send_point(20'sh80000, 20'sh7FFFF, 20'sd11);
        send_point(-20'sd5, 20'sd7, 20'sd16);
        send_point('0, '0, 20'sh80000);
        send_point('0, '0, -20'sd1);
        send_point(20'sh55555, 20'shAAAAA, 20'sh55555);
        send_point(20'shAAAAA, 20'sh55555, 20'shAAAAA);
        drain();

        // Extreme settings: zero and full-scale projection factors and half extents,
        // negated axes with the most negative component, camera at a far corner.
        write_reg(CFG_PROJ_X, '0);
        write_reg(CFG_PROJ_Y, 60'hFFFF);
        write_reg(CFG_HALF_W, '0);
        write_reg(CFG_HALF_H, 60'hFFF);
        write_reg(CFG_CAM_FWD, 60'(pack_axis(0, 0, -32768)));
        write_reg(CFG_CAM_POS, {20'h80000, 20'h7FFFF, 20'h80000});
        write_reg(CFG_CAM_RGT, 60'(pack_axis(32767, 32767, 32767)));
        write_reg(CFG_CAM_UP, 60'(pack_axis(-32768, -32768, -32768)));
        send_point('0, '0, 20'sh80000);
        send_point(20'sh7FFFF, 20'sh80000, 20'sh80000);
        send_point(20'sh80000, 20'sh7FFFF, 20'sh7FFFF);
        send_point(20'sd12, -20'sd40, 20'sh7FFF0);
        drain();

        // Random phases; one of them has no idling at all and one a long hold-off.
        for (phase = 0; phase < 9; phase++) begin
            random_camera(phase % 3 == 2);
            quiet_rx = (phase == 3);
            quiet_tx = (phase == 3);
            if (phase == 5) begin
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (200) @(negedge i_clk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            for (k = 0; k < 150; k++)
                send_point(rand_coord(k % 8 == 0), rand_coord(k % 8 == 0),
                           (k % 8 == 0) ? rand_coord(1) : 20'($urandom_range(3000)));
            drain();
        end
        quiet_rx = 1'b0;
        quiet_tx = 1'b0;

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
